FILE: sv/spal_pkg.sv
// spal_pkg: shared types and codes for the slot pool allocator
// no dependencies; imported by slot_pool_alloc_list
`timescale 1ns / 1ps

package spal_pkg;

  // fixed field widths
  localparam int ID_W   = 6;  // slot id field
  localparam int LINK_W = 7;  // link value, wide enough for the no-slot marker
  localparam int ACT_W  = 2;
  localparam int ST_W   = 2;

  typedef logic [ID_W-1:0]   slot_id_t;
  typedef logic [LINK_W-1:0] link_t;
  typedef logic [ACT_W-1:0]  action_t;
  typedef logic [ST_W-1:0]   status_t;

  // action codes
  localparam action_t ACT_ALLOC   = 2'd0;
  localparam action_t ACT_RELEASE = 2'd1;
  localparam action_t ACT_WALK    = 2'd2;

  // status codes
  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_FULL  = 2'd1;
  localparam status_t ST_FREE  = 2'd2;
  localparam status_t ST_EMPTY = 2'd3;

endpackage

FILE: sv/slot_pool_alloc_list.sv
// slot_pool_alloc_list: free list / used list slot allocator with a small sequencer
// depends on spal_pkg; link memories are local arrays with per-entry valid bits
`timescale 1ns / 1ps

// channel   ports                                         transfer
// --------  --------------------------------------------  -------------------------------
// input     start, busy, in_action, in_slot_id            rising edge with start & !busy
// result    out_valid, out_result_slot, out_status,       every edge with out_valid high
//           out_last
//
// allocate and release run in three steps each (read links, unlink/link, final
// write), as each link memory has a single write port. a walk returns one used slot
// per cycle, chained by the forward link read from slot to slot. full, already-free
// and empty cases finish in the accept cycle. each result appears in the cycle after
// the step that makes it, from an output register. reset is synchronous and takes
// effect at once: link entries carry valid bits, so no clearing pass is needed. the
// receiver cannot stall; busy is the only back pressure.

module slot_pool_alloc_list
  import spal_pkg::*;
#(
  parameter int SLOTS = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  action_t    in_action,
  input  slot_id_t   in_slot_id,
  output logic       out_valid,
  output slot_id_t   out_result_slot,
  output status_t    out_status,
  output logic       out_last
);

  localparam int    IW     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam link_t MARKER = LINK_W'(SLOTS);
  localparam link_t CNT_LAST = LINK_W'(SLOTS - 1);

  // sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_ALLOC1 = 3'd1;
  localparam logic [2:0] S_ALLOC2 = 3'd2;
  localparam logic [2:0] S_REL1   = 3'd3;
  localparam logic [2:0] S_REL2   = 3'd4;
  localparam logic [2:0] S_WALK   = 3'd5;

  logic [2:0]       state_r, state_nxt;
  link_t            free_ptr_r, free_ptr_nxt;
  link_t            used_ptr_r, used_ptr_nxt;
  link_t            used_cnt_r, used_cnt_nxt;
  logic [SLOTS-1:0] slot_free_r, slot_free_nxt;
  logic [IW-1:0]    op_id_r, op_id_nxt;
  logic [IW-1:0]    cur_r, cur_nxt;
  link_t            cnt_r, cnt_nxt;

  logic             out_valid_r, out_valid_nxt;
  slot_id_t         out_slot_r, out_slot_nxt;
  status_t          out_status_r, out_status_nxt;
  logic             out_last_r, out_last_nxt;

  // forward link memory
  link_t            fl_mem [SLOTS];
  logic [SLOTS-1:0] fl_vld_r;
  logic             fl_we, fl_re;
  logic [IW-1:0]    fl_waddr, fl_raddr;
  link_t            fl_wdata;
  link_t            fl_q_r;
  logic             fl_qv_r;
  logic [IW-1:0]    fl_qa_r;
  link_t            fl_rd;

  // back link memory
  slot_id_t         bl_mem [SLOTS];
  logic [SLOTS-1:0] bl_vld_r;
  logic             bl_we, bl_re;
  logic [IW-1:0]    bl_waddr, bl_raddr;
  slot_id_t         bl_wdata;
  slot_id_t         bl_q_r;
  logic             bl_qv_r;
  slot_id_t         bl_rd;

  logic             head_valid;
  logic             id_in_range;
  logic             id_is_free;
  logic [IW-1:0]    tail;
  logic [IW-1:0]    prev;
  link_t            next;
  logic             walk_last;

  // link memory storage, written and read in clocked blocks
  always_ff @(posedge clk) begin
    if (fl_we) begin
      fl_mem[fl_waddr] <= fl_wdata;
    end
    if (fl_re) begin
      fl_q_r  <= fl_mem[fl_raddr];
      fl_qv_r <= fl_vld_r[fl_raddr];
      fl_qa_r <= fl_raddr;
    end
  end

  always_ff @(posedge clk) begin
    if (bl_we) begin
      bl_mem[bl_waddr] <= bl_wdata;
    end
    if (bl_re) begin
      bl_q_r  <= bl_mem[bl_raddr];
      bl_qv_r <= bl_vld_r[bl_raddr];
    end
  end

  // entries never written read as their reset value
  assign fl_rd = fl_qv_r ? fl_q_r : (LINK_W'(fl_qa_r) + LINK_W'(1));
  assign bl_rd = bl_qv_r ? bl_q_r : '0;

  // valid bits for the link memories
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fl_vld_r <= '0;
      bl_vld_r <= '0;
    end else begin
      if (fl_we) begin
        fl_vld_r[fl_waddr] <= 1'b1;
      end
      if (bl_we) begin
        bl_vld_r[bl_waddr] <= 1'b1;
      end
    end
  end

  assign head_valid  = (used_ptr_r < MARKER);
  assign id_in_range = ({1'b0, in_slot_id} < MARKER);
  assign id_is_free  = id_in_range ? slot_free_r[in_slot_id[IW-1:0]] : 1'b1;
  assign tail        = head_valid ? bl_rd[IW-1:0] : op_id_r;
  assign prev        = bl_rd[IW-1:0];
  assign next        = fl_rd;
  assign walk_last   = (fl_rd >= MARKER) || (cnt_r == CNT_LAST);

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    free_ptr_nxt   = free_ptr_r;
    used_ptr_nxt   = used_ptr_r;
    used_cnt_nxt   = used_cnt_r;
    slot_free_nxt  = slot_free_r;
    op_id_nxt      = op_id_r;
    cur_nxt        = cur_r;
    cnt_nxt        = cnt_r;
    out_valid_nxt  = 1'b0;
    out_slot_nxt   = out_slot_r;
    out_status_nxt = out_status_r;
    out_last_nxt   = out_last_r;
    fl_we    = 1'b0;
    fl_waddr = op_id_r;
    fl_wdata = '0;
    fl_re    = 1'b0;
    fl_raddr = op_id_r;
    bl_we    = 1'b0;
    bl_waddr = op_id_r;
    bl_wdata = '0;
    bl_re    = 1'b0;
    bl_raddr = op_id_r;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          case (in_action)
            ACT_ALLOC: begin
              if (used_cnt_r >= MARKER || free_ptr_r >= MARKER) begin
                out_valid_nxt  = 1'b1;
                out_slot_nxt   = '0;
                out_status_nxt = ST_FULL;
                out_last_nxt   = 1'b1;
              end else begin
                // fetch next free slot and the current tail
                op_id_nxt = free_ptr_r[IW-1:0];
                fl_re     = 1'b1;
                fl_raddr  = free_ptr_r[IW-1:0];
                bl_re     = head_valid;
                bl_raddr  = used_ptr_r[IW-1:0];
                state_nxt = S_ALLOC1;
              end
            end
            ACT_RELEASE: begin
              if (id_is_free) begin
                out_valid_nxt  = 1'b1;
                out_slot_nxt   = '0;
                out_status_nxt = ST_FREE;
                out_last_nxt   = 1'b1;
              end else begin
                // fetch both neighbors of the slot
                op_id_nxt = in_slot_id[IW-1:0];
                fl_re     = 1'b1;
                fl_raddr  = in_slot_id[IW-1:0];
                bl_re     = 1'b1;
                bl_raddr  = in_slot_id[IW-1:0];
                state_nxt = S_REL1;
              end
            end
            ACT_WALK: begin
              if (!head_valid) begin
                out_valid_nxt  = 1'b1;
                out_slot_nxt   = '0;
                out_status_nxt = ST_EMPTY;
                out_last_nxt   = 1'b1;
              end else begin
                cur_nxt   = used_ptr_r[IW-1:0];
                cnt_nxt   = '0;
                fl_re     = 1'b1;
                fl_raddr  = used_ptr_r[IW-1:0];
                state_nxt = S_WALK;
              end
            end
            default: ;
          endcase
        end
      end

      // link new slot in front of the old head
      S_ALLOC1: begin
        free_ptr_nxt  = fl_rd;
        fl_we         = 1'b1;
        fl_waddr      = op_id_r;
        fl_wdata      = used_ptr_r;
        bl_we         = 1'b1;
        bl_waddr      = op_id_r;
        bl_wdata      = ID_W'(tail);
        state_nxt     = S_ALLOC2;
      end

      // old head points back at the new slot
      S_ALLOC2: begin
        bl_we                  = head_valid;
        bl_waddr               = used_ptr_r[IW-1:0];
        bl_wdata               = ID_W'(op_id_r);
        used_ptr_nxt           = LINK_W'(op_id_r);
        slot_free_nxt[op_id_r] = 1'b0;
        used_cnt_nxt           = used_cnt_r + LINK_W'(1);
        out_valid_nxt          = 1'b1;
        out_slot_nxt           = ID_W'(op_id_r);
        out_status_nxt         = ST_OK;
        out_last_nxt           = 1'b1;
        state_nxt              = S_IDLE;
      end

      // unlink: only slot, tail, head or middle
      S_REL1: begin
        if (prev == op_id_r) begin
          used_ptr_nxt = MARKER;
        end else if (next >= MARKER) begin
          fl_we    = 1'b1;
          fl_waddr = prev;
          fl_wdata = MARKER;
          bl_we    = head_valid;
          bl_waddr = used_ptr_r[IW-1:0];
          bl_wdata = ID_W'(prev);
        end else if (LINK_W'(op_id_r) == used_ptr_r) begin
          used_ptr_nxt = next;
          bl_we    = 1'b1;
          bl_waddr = next[IW-1:0];
          bl_wdata = ID_W'(prev);
        end else begin
          fl_we    = 1'b1;
          fl_waddr = prev;
          fl_wdata = next;
          bl_we    = 1'b1;
          bl_waddr = next[IW-1:0];
          bl_wdata = ID_W'(prev);
        end
        state_nxt = S_REL2;
      end

      // push released slot onto the free list
      S_REL2: begin
        fl_we                  = 1'b1;
        fl_waddr               = op_id_r;
        fl_wdata               = free_ptr_r;
        free_ptr_nxt           = LINK_W'(op_id_r);
        slot_free_nxt[op_id_r] = 1'b1;
        used_cnt_nxt           = used_cnt_r - LINK_W'(1);
        out_valid_nxt          = 1'b1;
        out_slot_nxt           = ID_W'(op_id_r);
        out_status_nxt         = ST_OK;
        out_last_nxt           = 1'b1;
        state_nxt              = S_IDLE;
      end

      // one used slot per cycle, chasing forward links
      S_WALK: begin
        out_valid_nxt  = 1'b1;
        out_slot_nxt   = ID_W'(cur_r);
        out_status_nxt = ST_OK;
        out_last_nxt   = walk_last;
        if (walk_last) begin
          state_nxt = S_IDLE;
        end else begin
          cur_nxt  = fl_rd[IW-1:0];
          cnt_nxt  = cnt_r + LINK_W'(1);
          fl_re    = 1'b1;
          fl_raddr = fl_rd[IW-1:0];
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      free_ptr_r  <= '0;
      used_ptr_r  <= MARKER;
      used_cnt_r  <= '0;
      slot_free_r <= '1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      free_ptr_r  <= free_ptr_nxt;
      used_ptr_r  <= used_ptr_nxt;
      used_cnt_r  <= used_cnt_nxt;
      slot_free_r <= slot_free_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // working registers and result payload
  always_ff @(posedge clk) begin
    op_id_r      <= op_id_nxt;
    cur_r        <= cur_nxt;
    cnt_r        <= cnt_nxt;
    out_slot_r   <= out_slot_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign busy            = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_result_slot = out_slot_r;
  assign out_status      = out_status_r;
  assign out_last        = out_last_r;

  // the sequencer only leaves idle on an accepted transfer
  a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && !start) |=> (state_r == S_IDLE))
    else $error("sequencer left idle without a transfer");

  // used count never exceeds the pool
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_cnt_r <= MARKER)
    else $error("used count beyond pool size");

  // between items, an empty count and a missing head go together
  a_empty_match: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> ((used_cnt_r == '0) == (used_ptr_r >= MARKER)))
    else $error("used count and used head disagree");

  // error and empty results always close their item
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != ST_OK) |-> out_last_r)
    else $error("non-ok result without last");

endmodule
